// File: hw/rtl/cfd_pkg.sv
package cfd_pkg;

  localparam int unsigned SampleCount = 5;
  localparam int unsigned AdcBits     = 11;
  localparam int unsigned CountBits   = 4;
  localparam int unsigned CfgIdxBits  = 2;
  localparam int unsigned CfgDataBits = 11;

  // sum of all samples, and of the middle ones after trimming
  localparam int unsigned SumBits  = AdcBits + $clog2(SampleCount);
  localparam int unsigned KeptBits = AdcBits + $clog2(SampleCount - 2);

  // divide by the kept-sample count via reciprocal multiply
  localparam int unsigned RecipShift = KeptBits + 4;
  localparam int unsigned RecipBits  = RecipShift - 1;
  localparam logic [RecipBits-1:0] RecipMul =
    RecipBits'(((64'd1 << RecipShift) + 64'(SampleCount - 2) - 64'd1) / 64'(SampleCount - 2));
  localparam int unsigned ProdBits = KeptBits + RecipBits;

  localparam logic [AdcBits-1:0] PreFullThreshRst = AdcBits'(388);
  localparam logic [AdcBits-1:0] FullThreshRst    = AdcBits'(250);
  localparam logic [CountBits-1:0] PreFullCountRst = CountBits'(5);
  localparam logic [CountBits-1:0] FullCountRst    = CountBits'(5);

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_PRE_FULL_THRESH = 2'd0,
    CFG_FULL_THRESH     = 2'd1,
    CFG_PRE_FULL_COUNT  = 2'd2,
    CFG_FULL_COUNT      = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    STATUS_NOT_FULL = 2'd0,
    STATUS_PRE_FULL = 2'd1,
    STATUS_FULL     = 2'd2
  } status_e;

  typedef logic [AdcBits-1:0] sample_t;
  typedef sample_t [SampleCount-1:0] sample_vec_t;

  typedef struct packed {
    logic read_failed;
    logic charger_enabled;
    logic charge_requested;
  } flags_t;

endpackage

// File: hw/rtl/cfd_mean.sv
module cfd_mean (
  input  logic [cfd_pkg::KeptBits-1:0] kept_i,
  output cfd_pkg::sample_t             mean_o
);
  import cfd_pkg::*;

  logic [ProdBits-1:0] prod;

  assign prod   = ProdBits'(kept_i) * ProdBits'(RecipMul);
  assign mean_o = prod[RecipShift +: AdcBits];

endmodule

// File: hw/rtl/cfd_trim_mean.sv
module cfd_trim_mean (
  input  cfd_pkg::sample_vec_t samples_i,
  output cfd_pkg::sample_t     mean_o
);
  import cfd_pkg::*;

  logic [SumBits-1:0]  total;
  logic [KeptBits-1:0] kept;
  sample_t             hi;
  sample_t             lo;

  always_comb begin
    hi    = samples_i[0];
    lo    = samples_i[0];
    total = SumBits'(samples_i[0]);
    for (int unsigned i = 1; i < SampleCount; i++) begin
      if (samples_i[i] > hi) hi = samples_i[i];
      if (samples_i[i] < lo) lo = samples_i[i];
      total = total + SumBits'(samples_i[i]);
    end
  end

  assign kept = KeptBits'(total - SumBits'(hi) - SumBits'(lo));

  cfd_mean u_div (
    .kept_i (kept),
    .mean_o (mean_o)
  );

endmodule

// File: hw/rtl/cfd_detect.sv
module cfd_detect (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [cfd_pkg::CfgIdxBits-1:0]      cfg_idx_i,
  input  logic [cfd_pkg::CfgDataBits-1:0]     cfg_data_i,
  input  logic                                step_i,
  input  cfd_pkg::flags_t                     flags_i,
  input  cfd_pkg::sample_t                    mean_i,
  output cfd_pkg::status_e                    status_o
);
  import cfd_pkg::*;

  sample_t              pre_thresh_q, full_thresh_q;
  logic [CountBits-1:0] pre_limit_q, full_limit_q;
  logic [CountBits-1:0] pre_cnt_q, pre_cnt_d, full_cnt_q, full_cnt_d;
  logic                 pre_flag_q, pre_flag_d, full_flag_q, full_flag_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_thresh_q  <= PreFullThreshRst;
      full_thresh_q <= FullThreshRst;
      pre_limit_q   <= PreFullCountRst;
      full_limit_q  <= FullCountRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_PRE_FULL_THRESH: pre_thresh_q  <= cfg_data_i[AdcBits-1:0];
        CFG_FULL_THRESH:     full_thresh_q <= cfg_data_i[AdcBits-1:0];
        CFG_PRE_FULL_COUNT:  pre_limit_q   <= cfg_data_i[CountBits-1:0];
        CFG_FULL_COUNT:      full_limit_q  <= cfg_data_i[CountBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    pre_cnt_d   = pre_cnt_q;
    full_cnt_d  = full_cnt_q;
    pre_flag_d  = pre_flag_q;
    full_flag_d = full_flag_q;
    if (!flags_i.charge_requested || (!flags_i.read_failed && !flags_i.charger_enabled)) begin
      pre_cnt_d   = '0;
      full_cnt_d  = '0;
      pre_flag_d  = 1'b0;
      full_flag_d = 1'b0;
    end else if (!flags_i.read_failed) begin
      if (!pre_flag_q && (mean_i < pre_thresh_q)) begin
        if (pre_cnt_q >= pre_limit_q) pre_flag_d = 1'b1;
        else                          pre_cnt_d  = pre_cnt_q + CountBits'(1);
      end else begin
        pre_cnt_d = '0;
      end
      if (!full_flag_q && (mean_i < full_thresh_q)) begin
        if (full_cnt_q >= full_limit_q) full_flag_d = 1'b1;
        else                            full_cnt_d  = full_cnt_q + CountBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_cnt_q   <= '0;
      full_cnt_q  <= '0;
      pre_flag_q  <= 1'b0;
      full_flag_q <= 1'b0;
    end else if (step_i) begin
      pre_cnt_q   <= pre_cnt_d;
      full_cnt_q  <= full_cnt_d;
      pre_flag_q  <= pre_flag_d;
      full_flag_q <= full_flag_d;
    end
  end

  always_comb begin
    if (full_flag_d)     status_o = STATUS_FULL;
    else if (pre_flag_d) status_o = STATUS_PRE_FULL;
    else                 status_o = STATUS_NOT_FULL;
  end

endmodule

// File: hw/rtl/charge_full_detector_unit.sv
// Channel   Dir  Payload
// s_axis    in   tdata: sample_a..sample_e, tuser: charge_requested, charger_enabled,
//                read_failed
// m_axis    out  tdata: charge_status, mean_current, tuser: read_error
// cfg       in   cfg_we_i / cfg_idx_i / cfg_data_i, one register per write
//
// One beat per cycle sustained while m_axis_tready is high; each beat is registered at input and output.
// The input register feeds trimmed mean and detection logic into the output register.
// Reset clears both stage valids, the counters and flags, and loads register defaults.
// A stalled output holds its beat; the input stage refills while the output drains.
module charge_full_detector_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [cfd_pkg::CfgIdxBits-1:0]    cfg_idx_i,
  input  logic [cfd_pkg::CfgDataBits-1:0]   cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [55:0]                       s_axis_tdata,  // sample_a..sample_e, 11 bits each, pad
  input  logic [2:0]                        s_axis_tuser,  // charge_requested, charger_enabled,
                                                           // read_failed
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [15:0]                       m_axis_tdata,  // charge_status, mean_current, pad
  output logic [0:0]                        m_axis_tuser   // read_error
);
  import cfd_pkg::*;

  logic        in_vld_q;
  sample_vec_t samples_q;
  flags_t      flags_q;
  logic        out_vld_q;
  status_e     status_q;
  logic        error_q;
  sample_t     mean_out_q;
  logic        advance;
  logic        compute_ok;
  sample_t     mean;
  status_e     status;

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      for (int unsigned i = 0; i < SampleCount; i++) begin
        samples_q[i] <= s_axis_tdata[i*AdcBits +: AdcBits];
      end
      flags_q <= flags_t'(s_axis_tuser);
    end
  end

  cfd_trim_mean u_mean (
    .samples_i (samples_q),
    .mean_o    (mean)
  );

  cfd_detect u_detect (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .step_i     (advance),
    .flags_i    (flags_q),
    .mean_i     (mean),
    .status_o   (status)
  );

  assign compute_ok = flags_q.charge_requested && !flags_q.read_failed;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || m_axis_tready) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      status_q   <= compute_ok ? status : STATUS_NOT_FULL;
      error_q    <= flags_q.charge_requested && flags_q.read_failed;
      mean_out_q <= compute_ok ? mean : '0;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {3'b000, mean_out_q, status_q};
  assign m_axis_tuser  = error_q;

endmodule

// File: bench/charge_full_detector_unit_test.sv
`timescale 1ns / 100ps

module charge_full_detector_unit_test;
  import cfd_pkg::*;

  localparam int unsigned IdleLimit = 500;
  localparam int unsigned PhaseBeats = 60;

  typedef struct packed {
    flags_t      flags;
    sample_vec_t samples;
  } charge_beat_t;

  typedef struct packed {
    status_e status;
    logic    read_error;
    sample_t mean;
  } charge_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CfgIdxBits-1:0]  cfg_idx_i;
  logic [CfgDataBits-1:0] cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [55:0]            s_axis_tdata;  // sample_a..sample_e, 11 bits each, pad
  logic [2:0]             s_axis_tuser;  // charge_requested, charger_enabled, read_failed
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [15:0]            m_axis_tdata;  // charge_status, mean_current, pad
  logic [0:0]             m_axis_tuser;  // read_error

  sample_t        pre_thr, full_thr;
  logic [3:0]     pre_lim, full_lim;
  logic [3:0]     pre_cnt, full_cnt;
  logic           pre_flag, full_flag;

  charge_result_t expected_results[$];
  charge_result_t want;
  int             errors = 0;
  int             beats_sent = 0;
  int             results_seen = 0;
  int             pre_full_seen = 0;
  int             full_seen = 0;
  int             settings_used = 0;
  int             stall_left = 0;
  int             idle_cycles = 0;
  bit             gaps_on = 1'b1;

  charge_full_detector_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic void clear_detection();
    pre_cnt   = '0;
    full_cnt  = '0;
    pre_flag  = 1'b0;
    full_flag = 1'b0;
  endfunction

  function automatic sample_t trimmed_mean(sample_vec_t s);
    logic [15:0] total;
    sample_t     hi, lo;
    logic [15:0] m;
    total = '0;
    hi    = '0;
    lo    = '1;
    for (int i = 0; i < SampleCount; i++) begin
      if (s[i] > hi) hi = s[i];
      if (s[i] < lo) lo = s[i];
      total += 16'(s[i]);
    end
    m = (total - 16'(hi) - 16'(lo)) / 16'(SampleCount - 2);
    return (m > 16'd2047) ? sample_t'(2047) : sample_t'(m);
  endfunction

  function automatic charge_result_t judge_beat(charge_beat_t b);
    charge_result_t r;
    sample_t        mean;
    r = '{status: STATUS_NOT_FULL, read_error: 1'b0, mean: '0};
    if (!b.flags.charge_requested) begin
      clear_detection();
      return r;
    end
    if (b.flags.read_failed) begin
      r.read_error = 1'b1;
      return r;
    end
    mean = trimmed_mean(b.samples);
    if (b.flags.charger_enabled) begin
      if (!pre_flag && mean < pre_thr) begin
        if (pre_cnt >= pre_lim) pre_flag = 1'b1;
        else pre_cnt = pre_cnt + 4'd1;
      end else begin
        pre_cnt = '0;
      end
      if (!full_flag && mean < full_thr) begin
        if (full_cnt >= full_lim) full_flag = 1'b1;
        else full_cnt = full_cnt + 4'd1;
      end
    end else begin
      clear_detection();
    end
    if (full_flag) r.status = STATUS_FULL;
    else if (pre_flag) r.status = STATUS_PRE_FULL;
    r.mean = mean;
    return r;
  endfunction

  function automatic charge_beat_t make_beat(int a, int b, int c, int d, int e,
                                             bit req, bit en, bit fail);
    charge_beat_t x;
    x.samples[0] = sample_t'(a);
    x.samples[1] = sample_t'(b);
    x.samples[2] = sample_t'(c);
    x.samples[3] = sample_t'(d);
    x.samples[4] = sample_t'(e);
    x.flags.charge_requested = req;
    x.flags.charger_enabled  = en;
    x.flags.read_failed      = fail;
    return x;
  endfunction

  function automatic charge_beat_t random_beat();
    charge_beat_t x;
    int           kind, centre, spread, v;
    kind   = $urandom_range(0, 99);
    centre = $urandom_range(0, 1) ? int'(pre_thr) : int'(full_thr);
    spread = ($urandom_range(0, 3) == 0) ? 400 : int'($urandom_range(0, 40));
    for (int i = 0; i < SampleCount; i++) begin
      if (kind < 20) begin
        x.samples[i] = sample_t'($urandom_range(0, 2047));
      end else begin
        v = centre + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > 2047) v = 2047;
        x.samples[i] = sample_t'(v);
      end
    end
    x.flags.charge_requested = (kind >= 4);
    x.flags.read_failed      = (kind < 4) ? 1'($urandom_range(0, 1)) : (kind < 10);
    x.flags.charger_enabled  = (kind < 4) ? 1'($urandom_range(0, 1)) :
                               !(kind >= 10 && kind < 15);
    return x;
  endfunction

  task automatic send_beat(charge_beat_t b);
    int gap;
    gap = gaps_on ? int'($urandom_range(0, 4)) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, b.samples};
    s_axis_tuser  <= b.flags;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_results.push_back(judge_beat(b));
    beats_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, int value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CfgDataBits'(value);
    case (idx)
      CFG_PRE_FULL_THRESH: pre_thr  = sample_t'(value);
      CFG_FULL_THRESH:     full_thr = sample_t'(value);
      CFG_PRE_FULL_COUNT:  pre_lim  = 4'(value);
      CFG_FULL_COUNT:      full_lim = 4'(value);
      default: ;
    endcase
  endtask

  task automatic load_settings(int pt, int ft, int pc, int fc);
    drain();
    write_reg(CFG_PRE_FULL_THRESH, pt);
    write_reg(CFG_FULL_THRESH, ft);
    write_reg(CFG_PRE_FULL_COUNT, pc);
    write_reg(CFG_FULL_COUNT, fc);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 20 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      send_beat(random_beat());
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_field_edges();
    send_beat(make_beat(0, 0, 0, 0, 0, 1, 1, 0));
    send_beat(make_beat(2047, 2047, 2047, 2047, 2047, 1, 1, 0));
    send_beat(make_beat(0, 2047, 1000, 1001, 1002, 1, 1, 0));
    send_beat(make_beat(5, 5, 5, 9, 0, 1, 1, 0));
    send_beat(make_beat(2047, 0, 2047, 0, 2047, 1, 1, 0));
    send_beat(make_beat(1234, 1234, 1234, 1234, 1234, 1, 1, 1));
    send_beat(make_beat(2047, 2047, 2047, 2047, 2047, 0, 1, 1));
    send_beat(make_beat(700, 800, 900, 1000, 1100, 1, 0, 0));
    send_beat(make_beat(0, 0, 0, 0, 0, 0, 0, 0));
    send_beat(make_beat(388, 388, 388, 388, 388, 1, 1, 0));
    send_beat(make_beat(387, 387, 387, 387, 387, 1, 1, 0));
    send_beat(make_beat(250, 250, 250, 250, 250, 1, 1, 0));
    send_beat(make_beat(249, 249, 249, 249, 249, 1, 1, 0));
  endtask

  task automatic test_debounce();
    send_beat(make_beat(0, 0, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < 8; i++) send_beat(make_beat(90, 100, 110, 95, 105, 1, 1, 0));
    send_beat(make_beat(90, 100, 110, 95, 105, 1, 1, 1));
    send_beat(make_beat(300, 300, 300, 300, 300, 1, 1, 0));
    send_beat(make_beat(100, 100, 100, 100, 100, 1, 0, 0));
    send_beat(make_beat(100, 100, 100, 100, 100, 1, 1, 0));
  endtask

  task automatic test_register_extremes();
    load_settings(0, 0, 0, 0);
    run_random(PhaseBeats);
    load_settings(2047, 2047, 15, 15);
    run_random(PhaseBeats);
    load_settings(2047, 0, 0, 15);
    run_random(PhaseBeats);
    load_settings(0, 2047, 15, 0);
    run_random(PhaseBeats);
  endtask

  task automatic test_random_settings();
    load_settings(388, 250, 5, 5);
    run_random(PhaseBeats);
    repeat (3) begin
      load_settings($urandom_range(0, 2047), $urandom_range(0, 2047),
                    $urandom_range(0, 15), $urandom_range(0, 15));
      run_random(PhaseBeats);
    end
  endtask

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      stall_left = gaps_on ? int'($urandom_range(0, 4)) : 0;
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected: tdata %h tuser %b",
               m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tdata[1:0] != want.status) begin
          $error("charge_status: expected %0d, got %0d", want.status, m_axis_tdata[1:0]);
          errors++;
        end
        if (m_axis_tuser[0] != want.read_error) begin
          $error("read_error: expected %0d, got %0d", want.read_error, m_axis_tuser[0]);
          errors++;
        end
        if (m_axis_tdata[12:2] != want.mean) begin
          $error("mean_current: expected %0d, got %0d", want.mean, m_axis_tdata[12:2]);
          errors++;
        end
        if (want.status == STATUS_PRE_FULL) pre_full_seen++;
        if (want.status == STATUS_FULL) full_seen++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: %0d cycles without a beat, %0d results outstanding",
                 idle_cycles, expected_results.size());
        $display("charge_full_detector_unit_test NOT OK");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    pre_thr       = PreFullThreshRst;
    full_thr      = FullThreshRst;
    pre_lim       = PreFullCountRst;
    full_lim      = FullCountRst;
    clear_detection();
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    test_field_edges();
    test_debounce();
    test_register_extremes();
    test_random_settings();
    drain();

    $display("%0d input beats, %0d results checked over %0d register settings",
             beats_sent, results_seen, settings_used + 1);
    $display("pre-full reported %0d times, full reported %0d times",
             pre_full_seen, full_seen);
    if (errors == 0) begin
      $display("charge_full_detector_unit_test OK");
    end else begin
      $display("charge_full_detector_unit_test NOT OK");
    end
    $finish;
  end

endmodule
